// ----- hdl/jfa_pkg.sv -----
package jfa_pkg;

   localparam int COORD_BITS   = 16;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int SCALED_BITS  = 16;
   localparam int PROD_BITS    = 2 * SCALED_BITS;
   localparam int CROSS_BITS   = PROD_BITS + 1;
   localparam int MAG_BITS     = 32;
   localparam int SQ_BITS      = 64;
   localparam int SQRT_CELLS   = SQ_BITS / 2;
   localparam int NORM_CELLS   = 5;
   localparam int NORM_TOP     = 30;
   localparam int CORDIC_STEPS = 22;
   localparam int XY_BITS      = 36;
   localparam int ANG_BITS     = 24;
   localparam int FLEX_BITS    = 15;

   localparam logic signed [ANG_BITS-1:0] QUARTER_TURN = 24'sd2304000;
   localparam logic signed [ANG_BITS-1:0] HALF_TURN    = 24'sd4608000;
   localparam logic [FLEX_BITS-1:0]       FLEX_STRAIGHT = 15'd18000;
   localparam logic [7:0]                 CONF_RESET    = 8'd26;

   typedef struct packed {
      logic neg;
      logic measured;
      logic degenerate;
   } flags_type;

   typedef struct packed {
      logic                valid;
      logic [SQ_BITS-1:0]  n;
      logic [SQ_BITS-1:0]  r;
      logic [MAG_BITS-1:0] x;
      flags_type           flags;
   } sqrt_type;

   typedef struct packed {
      logic                valid;
      logic [MAG_BITS-1:0] ux;
      logic [MAG_BITS-1:0] uy;
      flags_type           flags;
   } norm_type;

   typedef struct packed {
      logic                       valid;
      logic signed [XY_BITS-1:0]  x;
      logic signed [XY_BITS-1:0]  y;
      logic signed [ANG_BITS-1:0] z;
      flags_type                  flags;
   } cordic_type;

   function automatic logic signed [ANG_BITS-1:0] atan_of(input logic [4:0] i);
      logic signed [ANG_BITS-1:0] a;
      case (i)
         5'd0:    a = 24'sd1152000;
         5'd1:    a = 24'sd680065;
         5'd2:    a = 24'sd359328;
         5'd3:    a = 24'sd182400;
         5'd4:    a = 24'sd91554;
         5'd5:    a = 24'sd45822;
         5'd6:    a = 24'sd22916;
         5'd7:    a = 24'sd11459;
         5'd8:    a = 24'sd5730;
         5'd9:    a = 24'sd2865;
         5'd10:   a = 24'sd1432;
         5'd11:   a = 24'sd716;
         5'd12:   a = 24'sd358;
         5'd13:   a = 24'sd179;
         5'd14:   a = 24'sd90;
         5'd15:   a = 24'sd45;
         5'd16:   a = 24'sd22;
         5'd17:   a = 24'sd11;
         5'd18:   a = 24'sd6;
         5'd19:   a = 24'sd3;
         5'd20:   a = 24'sd1;
         5'd21:   a = 24'sd1;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ----- hdl/jfa_sqrt_cell.sv -----
module jfa_sqrt_cell
   import jfa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic [4:0] step,
   input  sqrt_type d_in,
   output sqrt_type d_out
);

   sqrt_type           q_ff, q_in;
   logic [5:0]         sh;
   logic [SQ_BITS-1:0] bit_w, trial;

   always_comb begin
      sh    = 6'd62 - {step, 1'b0};
      bit_w = {{(SQ_BITS-1){1'b0}}, 1'b1} << sh;
      trial = d_in.r + bit_w;
      q_in  = d_in;
      if (d_in.n >= trial) begin
         q_in.n = d_in.n - trial;
         q_in.r = (d_in.r >> 1) + bit_w;
      end else begin
         q_in.r = d_in.r >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (en) begin
         q_ff <= q_in;
      end
   end

   assign d_out = q_ff;

endmodule

// ----- hdl/jfa_norm_cell.sv -----
module jfa_norm_cell
   import jfa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic [4:0] shift,
   input  norm_type d_in,
   output norm_type d_out
);

   norm_type            q_ff, q_in;
   logic [MAG_BITS-1:0] mx, limit;

   always_comb begin
      mx    = (d_in.ux > d_in.uy) ? d_in.ux : d_in.uy;
      limit = {{(MAG_BITS-1){1'b0}}, 1'b1} << (5'(NORM_TOP) - shift);
      q_in  = d_in;
      if (mx < limit) begin
         q_in.ux = d_in.ux << shift;
         q_in.uy = d_in.uy << shift;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (en) begin
         q_ff <= q_in;
      end
   end

   assign d_out = q_ff;

endmodule

// ----- hdl/jfa_cordic_cell.sv -----
module jfa_cordic_cell
   import jfa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic [4:0] step,
   input  cordic_type d_in,
   output cordic_type d_out
);

   cordic_type                q_ff, q_in;
   logic signed [XY_BITS-1:0] xs, ys;

   always_comb begin
      xs   = d_in.x >>> step;
      ys   = d_in.y >>> step;
      q_in = d_in;
      if (d_in.y > 0) begin
         q_in.x = d_in.x + ys;
         q_in.y = d_in.y - xs;
         q_in.z = d_in.z + atan_of(step);
      end else begin
         q_in.x = d_in.x - ys;
         q_in.y = d_in.y + xs;
         q_in.z = d_in.z - atan_of(step);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (en) begin
         q_ff <= q_in;
      end
   end

   assign d_out = q_ff;

endmodule

// ----- hdl/joint_flexion_angle_top.sv -----
// Flexion angle at a joint from three 3D points: one request per clock cycle
// is taken while the pipeline is not held, and each gives one response through
// the pipeline of six arithmetic stages, 32 square-root cells, one rounding
// stage, five normalizing cells, 22 CORDIC cells and the output register;
// while a response waits on rsp_tready the whole pipeline holds.
module joint_flexion_angle_top
   import jfa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // proximal_x/y/z, vertex_x/y/z, distal_x/y/z, proximal/vertex/distal_confidence
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // flexion_centideg, one zero bit
   output logic [15:0]  rsp_tdata,
   // measured, degenerate
   output logic [1:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_data
);

   logic en;
   logic [7:0] thr_ff;

   logic                        s1_valid_ff, s1_meas_ff;
   logic signed [DIFF_BITS-1:0] s1_a_ff [3];
   logic signed [DIFF_BITS-1:0] s1_b_ff [3];

   logic                          s2_valid_ff, s2_meas_ff, s2_degen_ff;
   logic signed [SCALED_BITS-1:0] s2_a_ff [3];
   logic signed [SCALED_BITS-1:0] s2_b_ff [3];
   logic signed [SCALED_BITS-1:0] s2_a_in [3];
   logic signed [SCALED_BITS-1:0] s2_b_in [3];

   logic                        s3_valid_ff;
   flags_type                   s3_flags_ff;
   logic signed [PROD_BITS-1:0] s3_p_ff [9];

   logic                s4_valid_ff;
   flags_type           s4_flags_ff;
   logic [MAG_BITS-1:0] s4_c_ff [3];
   logic [MAG_BITS-1:0] s4_d_ff;
   logic signed [CROSS_BITS-1:0] cr_in [3];
   logic signed [CROSS_BITS-1:0] dot_in;

   logic               s5_valid_ff;
   flags_type          s5_flags_ff;
   logic [SQ_BITS-1:0] s5_q_ff [3];
   logic [MAG_BITS-1:0] s5_d_ff;

   sqrt_type   s6_ff;
   sqrt_type   sq_chain [SQRT_CELLS+1];
   norm_type   rnd_ff;
   norm_type   nm_chain [NORM_CELLS+1];
   cordic_type cd_chain [CORDIC_STEPS+1];

   logic                       out_valid_ff;
   logic [FLEX_BITS-1:0]       out_flex_ff, out_flex_in;
   logic                       out_meas_ff, out_degen_ff;
   logic signed [ANG_BITS-1:0] ang, turn;

   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= CONF_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   function automatic logic signed [DIFF_BITS-1:0] coord(input logic [15:0] raw);
      return DIFF_BITS'($signed(raw));
   endfunction

   // Stage 1: confidence test and difference vectors.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_meas_ff <= (req_tdata[151:144] >= thr_ff) && (req_tdata[159:152] >= thr_ff)
                       && (req_tdata[167:160] >= thr_ff);
         for (int k = 0; k < 3; k++) begin
            s1_a_ff[k] <= coord(req_tdata[16*k +: 16]) - coord(req_tdata[48 + 16*k +: 16]);
            s1_b_ff[k] <= coord(req_tdata[96 + 16*k +: 16])
                          - coord(req_tdata[48 + 16*k +: 16]);
         end
      end
   end

   // Stage 2: zero test and scaling to 16 bits.
   function automatic logic [DIFF_BITS-1:0] mag17(input logic signed [DIFF_BITS-1:0] v);
      return v[DIFF_BITS-1] ? DIFF_BITS'(-v) : DIFF_BITS'(v);
   endfunction

   always_comb begin
      logic [DIFF_BITS-1:0] ma, mb, ta, tb;
      int sa, sb;
      ma = '0;
      mb = '0;
      for (int k = 0; k < 3; k++) begin
         if (mag17(s1_a_ff[k]) > ma) ma = mag17(s1_a_ff[k]);
         if (mag17(s1_b_ff[k]) > mb) mb = mag17(s1_b_ff[k]);
      end
      sa = 0;
      sb = 0;
      for (int s = DIFF_BITS - SCALED_BITS; s >= 0; s--) begin
         if ((ma >> s) <= DIFF_BITS'(32767)) sa = s;
         if ((mb >> s) <= DIFF_BITS'(32767)) sb = s;
      end
      for (int k = 0; k < 3; k++) begin
         ta = mag17(s1_a_ff[k]) >> sa;
         tb = mag17(s1_b_ff[k]) >> sb;
         s2_a_in[k] = s1_a_ff[k][DIFF_BITS-1] ? -$signed(ta[SCALED_BITS-1:0])
                                               : $signed(ta[SCALED_BITS-1:0]);
         s2_b_in[k] = s1_b_ff[k][DIFF_BITS-1] ? -$signed(tb[SCALED_BITS-1:0])
                                               : $signed(tb[SCALED_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_meas_ff  <= s1_meas_ff;
         s2_degen_ff <= (s1_a_ff[0] == 0 && s1_a_ff[1] == 0 && s1_a_ff[2] == 0)
                        || (s1_b_ff[0] == 0 && s1_b_ff[1] == 0 && s1_b_ff[2] == 0);
         s2_a_ff     <= s2_a_in;
         s2_b_ff     <= s2_b_in;
      end
   end

   // Stage 3: products.
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_flags_ff <= '{neg: 1'b0, measured: s2_meas_ff, degenerate: s2_degen_ff};
         s3_p_ff[0]  <= s2_a_ff[1] * s2_b_ff[2];
         s3_p_ff[1]  <= s2_a_ff[2] * s2_b_ff[1];
         s3_p_ff[2]  <= s2_a_ff[2] * s2_b_ff[0];
         s3_p_ff[3]  <= s2_a_ff[0] * s2_b_ff[2];
         s3_p_ff[4]  <= s2_a_ff[0] * s2_b_ff[1];
         s3_p_ff[5]  <= s2_a_ff[1] * s2_b_ff[0];
         s3_p_ff[6]  <= s2_a_ff[0] * s2_b_ff[0];
         s3_p_ff[7]  <= s2_a_ff[1] * s2_b_ff[1];
         s3_p_ff[8]  <= s2_a_ff[2] * s2_b_ff[2];
      end
   end

   // Stage 4: cross and dot, magnitudes.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cr_in[k] = CROSS_BITS'(s3_p_ff[2*k]) - CROSS_BITS'(s3_p_ff[2*k+1]);
      end
      dot_in = CROSS_BITS'(s3_p_ff[6]) + CROSS_BITS'(s3_p_ff[7]) + CROSS_BITS'(s3_p_ff[8]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_flags_ff <= '{neg: dot_in[CROSS_BITS-1], measured: s3_flags_ff.measured,
                          degenerate: s3_flags_ff.degenerate};
         for (int k = 0; k < 3; k++) begin
            s4_c_ff[k] <= cr_in[k][CROSS_BITS-1] ? MAG_BITS'(-cr_in[k]) : MAG_BITS'(cr_in[k]);
         end
         s4_d_ff <= dot_in[CROSS_BITS-1] ? MAG_BITS'(-dot_in) : MAG_BITS'(dot_in);
      end
   end

   // Stage 5: squares.
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_flags_ff <= s4_flags_ff;
         s5_d_ff     <= s4_d_ff;
         for (int k = 0; k < 3; k++) begin
            s5_q_ff[k] <= SQ_BITS'(s4_c_ff[k]) * SQ_BITS'(s4_c_ff[k]);
         end
      end
   end

   // Stage 6: sum of squares.
   always_ff @(posedge clock) begin
      if (reset) begin
         s6_ff.valid <= 1'b0;
      end else if (en) begin
         s6_ff.valid <= s5_valid_ff;
         s6_ff.n     <= s5_q_ff[0] + s5_q_ff[1] + s5_q_ff[2];
         s6_ff.r     <= '0;
         s6_ff.x     <= s5_d_ff;
         s6_ff.flags <= s5_flags_ff;
      end
   end

   assign sq_chain[0] = s6_ff;

   for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
      jfa_sqrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .step  (5'(i)),
         .d_in  (sq_chain[i]),
         .d_out (sq_chain[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_ff.valid <= 1'b0;
      end else if (en) begin
         rnd_ff.valid <= sq_chain[SQRT_CELLS].valid;
         rnd_ff.ux    <= sq_chain[SQRT_CELLS].x;
         rnd_ff.uy    <= MAG_BITS'(sq_chain[SQRT_CELLS].r
                         + SQ_BITS'(sq_chain[SQRT_CELLS].n > sq_chain[SQRT_CELLS].r));
         rnd_ff.flags <= sq_chain[SQRT_CELLS].flags;
      end
   end

   assign nm_chain[0] = rnd_ff;

   for (genvar i = 0; i < NORM_CELLS; i++) begin : g_norm
      jfa_norm_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .shift (5'(1 << (NORM_CELLS - 1 - i))),
         .d_in  (nm_chain[i]),
         .d_out (nm_chain[i+1])
      );
   end

   always_comb begin
      cd_chain[0].valid = nm_chain[NORM_CELLS].valid;
      cd_chain[0].x     = XY_BITS'(nm_chain[NORM_CELLS].ux);
      cd_chain[0].y     = XY_BITS'(nm_chain[NORM_CELLS].uy);
      cd_chain[0].z     = '0;
      cd_chain[0].flags = nm_chain[NORM_CELLS].flags;
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      jfa_cordic_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .step  (5'(i)),
         .d_in  (cd_chain[i]),
         .d_out (cd_chain[i+1])
      );
   end

   always_comb begin
      logic signed [ANG_BITS-1:0] z;
      z = cd_chain[CORDIC_STEPS].z;
      if (z < 0) begin
         ang = '0;
      end else if (z > QUARTER_TURN) begin
         ang = QUARTER_TURN;
      end else begin
         ang = z;
      end
      turn        = cd_chain[CORDIC_STEPS].flags.neg ? ang : HALF_TURN - ang;
      turn        = turn + 24'sd128;
      out_flex_in = turn[FLEX_BITS+7:8];
      if (!cd_chain[CORDIC_STEPS].flags.measured) begin
         out_flex_in = '0;
      end else if (cd_chain[CORDIC_STEPS].flags.degenerate) begin
         out_flex_in = FLEX_STRAIGHT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= cd_chain[CORDIC_STEPS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_flex_ff  <= out_flex_in;
         out_meas_ff  <= cd_chain[CORDIC_STEPS].flags.measured;
         out_degen_ff <= cd_chain[CORDIC_STEPS].flags.measured
                         && cd_chain[CORDIC_STEPS].flags.degenerate;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_flex_ff};
   assign rsp_tuser  = {out_degen_ff, out_meas_ff};

   a_unmeasured_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 16'd0 && !rsp_tuser[1])
      else $error("unmeasured response carries data");

   a_degenerate_straight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 16'(FLEX_STRAIGHT))
      else $error("degenerate response is not straight");

   a_flex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= 16'(FLEX_STRAIGHT))
      else $error("flexion out of range");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(cd_chain[CORDIC_STEPS].valid) && $stable(rnd_ff.valid))
      else $error("pipeline moved during stall");

endmodule

// ----- tb/joint_flexion_angle_top_test.sv -----
module joint_flexion_angle_top_test;
   import jfa_pkg::*;

   typedef struct {
      logic signed [15:0] coord[9];
      logic [7:0]         conf[3];
   } joint_set_type;

   typedef struct {
      logic [FLEX_BITS-1:0] flexion;
      logic                 measured;
      logic                 degenerate;
   } flexion_type;

   localparam int DRAIN_CYCLES = 80;
   localparam int STALL_LIMIT  = 3000;
   localparam int QUARTER      = 2304000;
   localparam int HALF         = 4608000;
   localparam longint ATAN[22] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916,
      11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1};

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [167:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [15:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_valid;
   logic         csr_ready;
   logic [7:0]   csr_data;

   flexion_type  flexion_q[$];
   logic [7:0]   threshold;
   bit           calm;
   int           mismatches;
   int           idle_count;

   joint_flexion_angle_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned round_root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      if (n > r) r++;
      return r;
   endfunction

   function automatic longint vector_angle(longint unsigned ux, longint unsigned uy);
      longint x, y, z, xs, ys;
      if (ux == 0 && uy == 0) return 0;
      while ((ux > uy ? ux : uy) < (64'd1 << 30)) begin
         ux <<= 1;
         uy <<= 1;
      end
      x = ux;
      y = uy;
      z = 0;
      for (int i = 0; i < 22; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += ATAN[i];
         end else begin
            x -= ys; y += xs; z -= ATAN[i];
         end
      end
      if (z < 0) z = 0;
      if (z > QUARTER) z = QUARTER;
      return z;
   endfunction

   function automatic void shrink(ref longint v[3]);
      longint m, q;
      int s;
      m = 0;
      s = 0;
      for (int k = 0; k < 3; k++) if ((v[k] < 0 ? -v[k] : v[k]) > m) m = v[k] < 0 ? -v[k] : v[k];
      while ((m >> s) > 32767) s++;
      for (int k = 0; k < 3; k++) begin
         q = (v[k] < 0 ? -v[k] : v[k]) >> s;
         v[k] = v[k] < 0 ? -q : q;
      end
   endfunction

   function automatic flexion_type predict_flexion(joint_set_type j);
      flexion_type res;
      longint a[3], b[3];
      longint cx, cy, cz, d, f;
      longint unsigned sq;
      res = '{0, 0, 0};
      if (j.conf[0] < threshold || j.conf[1] < threshold || j.conf[2] < threshold)
         return res;
      res.measured = 1;
      for (int k = 0; k < 3; k++) begin
         a[k] = longint'(j.coord[k]) - longint'(j.coord[3+k]);
         b[k] = longint'(j.coord[6+k]) - longint'(j.coord[3+k]);
      end
      if ((a[0] == 0 && a[1] == 0 && a[2] == 0) || (b[0] == 0 && b[1] == 0 && b[2] == 0)) begin
         res.flexion = FLEX_STRAIGHT;
         res.degenerate = 1;
         return res;
      end
      shrink(a);
      shrink(b);
      cx = a[1] * b[2] - a[2] * b[1];
      cy = a[2] * b[0] - a[0] * b[2];
      cz = a[0] * b[1] - a[1] * b[0];
      d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
      sq = longint'(cx * cx) + longint'(cy * cy) + longint'(cz * cz);
      f = vector_angle(d < 0 ? -d : d, round_root(sq));
      if (d >= 0) f = HALF - f;
      res.flexion = FLEX_BITS'((f + 128) >> 8);
      return res;
   endfunction

   function automatic joint_set_type joints(int p[3], int v[3], int dd[3], int c[3]);
      joint_set_type j;
      for (int k = 0; k < 3; k++) begin
         j.coord[k] = 16'(p[k]);
         j.coord[3+k] = 16'(v[k]);
         j.coord[6+k] = 16'(dd[k]);
         j.conf[k] = 8'(c[k]);
      end
      return j;
   endfunction

   task automatic send_joints(joint_set_type j);
      logic [167:0] packed_set;
      for (int k = 0; k < 9; k++) packed_set[16*k +: 16] = j.coord[k];
      for (int k = 0; k < 3; k++) packed_set[144 + 8*k +: 8] = j.conf[k];
      if (!calm && $urandom_range(99) < 18) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      flexion_q = {flexion_q, predict_flexion(j)};
      req_tvalid <= 1;
      req_tdata <= packed_set;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic end_burst();
      req_tvalid <= 0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (flexion_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [7:0] value);
      wait_drained();
      csr_valid <= 1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      threshold = value;
   endtask

   function automatic joint_set_type random_joints();
      joint_set_type j;
      int span;
      span = $urandom_range(3) == 0 ? 65535 : (1 << $urandom_range(1, 12)) - 1;
      for (int k = 0; k < 9; k++)
         j.coord[k] = span == 65535 ? 16'($urandom) : 16'($urandom_range(span) - span / 2);
      case ($urandom_range(19))
         0: for (int k = 0; k < 3; k++) j.coord[k] = j.coord[3+k];
         1: for (int k = 0; k < 3; k++) j.coord[6+k] = j.coord[3+k];
         default: ;
      endcase
      for (int k = 0; k < 3; k++)
         j.conf[k] = $urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(255, threshold));
      return j;
   endfunction

   task automatic test_directed();
      send_joints(joints('{1, 0, 0}, '{0, 0, 0}, '{0, 1, 0}, '{255, 255, 255}));
      send_joints(joints('{5, 0, 0}, '{0, 0, 0}, '{9, 0, 0}, '{26, 26, 26}));
      send_joints(joints('{-7, 0, 0}, '{0, 0, 0}, '{3, 0, 0}, '{200, 200, 200}));
      send_joints(joints('{32767, 32767, 32767}, '{-32768, -32768, -32768},
                         '{-32768, 32767, -32768}, '{255, 255, 255}));
      send_joints(joints('{-32768, 0, 32767}, '{32767, -32768, 0},
                         '{32767, 32767, -32768}, '{100, 100, 100}));
      send_joints(joints('{3, 4, 5}, '{3, 4, 5}, '{1, 2, 3}, '{80, 80, 80}));
      send_joints(joints('{1, 2, 3}, '{3, 4, 5}, '{3, 4, 5}, '{80, 80, 80}));
      send_joints(joints('{9, 9, 9}, '{9, 9, 9}, '{9, 9, 9}, '{80, 80, 80}));
      send_joints(joints('{1, 2, 3}, '{0, 0, 0}, '{4, 5, 6}, '{25, 80, 80}));
      send_joints(joints('{1, 2, 3}, '{0, 0, 0}, '{4, 5, 6}, '{80, 25, 80}));
      send_joints(joints('{1, 2, 3}, '{0, 0, 0}, '{4, 5, 6}, '{80, 80, 0}));
      send_joints(joints('{1, 1, 0}, '{0, 0, 0}, '{1, 0, 0}, '{26, 255, 26}));
      send_joints(joints('{1000, 1, 0}, '{0, 0, 0}, '{-1000, 0, 0}, '{90, 90, 90}));
      send_joints(joints('{0, 0, -32768}, '{0, 0, 32767}, '{0, 32767, 32767},
                         '{90, 90, 90}));
      end_burst();
   endtask

   task automatic test_threshold_extremes();
      write_threshold(8'd0);
      send_joints(joints('{1, 2, 3}, '{0, 0, 0}, '{3, 2, 1}, '{0, 0, 0}));
      send_joints(joints('{0, 0, 0}, '{0, 0, 0}, '{3, 2, 1}, '{0, 255, 0}));
      end_burst();
      write_threshold(8'd255);
      send_joints(joints('{1, 2, 3}, '{0, 0, 0}, '{3, 2, 1}, '{255, 255, 255}));
      send_joints(joints('{1, 2, 3}, '{0, 0, 0}, '{3, 2, 1}, '{254, 255, 255}));
      end_burst();
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) begin
         if (n % 300 == 0) begin
            end_burst();
            write_threshold(8'($urandom));
         end
         calm = (n % 500) >= 400;
         send_joints(random_joints());
      end
      calm = 0;
      end_burst();
   endtask

   task automatic test_pause_until_empty();
      for (int n = 0; n < 20; n++) send_joints(random_joints());
      end_burst();
      while (flexion_q.size() != 0) @(posedge clock);
      for (int n = 0; n < 20; n++) send_joints(random_joints());
      end_burst();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         rsp_tready <= calm || $urandom_range(99) >= 18;
      end
   end

   always @(posedge clock) begin
      flexion_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (flexion_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response %h/%b", rsp_tdata, rsp_tuser);
         end else begin
            want = flexion_q.pop_front();
            if (rsp_tdata[14:0] !== want.flexion || rsp_tdata[15] !== 1'b0 ||
                rsp_tuser[0] !== want.measured || rsp_tuser[1] !== want.degenerate) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected flexion %0d measured %b degenerate %b, got %0d %b %b",
                           want.flexion, want.measured, want.degenerate,
                           rsp_tdata[14:0], rsp_tuser[0], rsp_tuser[1]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      reset <= 1;
      req_tvalid <= 0;
      req_tdata <= '0;
      csr_valid <= 0;
      csr_data <= '0;
      threshold = CONF_RESET;
      calm = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_threshold_extremes();
      write_threshold(CONF_RESET);
      test_pause_until_empty();
      test_random(1500);
      wait_drained();
      if (mismatches == 0 && flexion_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/jfa_pkg.sv
hdl/jfa_sqrt_cell.sv
hdl/jfa_norm_cell.sv
hdl/jfa_cordic_cell.sv
hdl/joint_flexion_angle_top.sv
tb/joint_flexion_angle_top_test.sv
